// ===== rtl/ptm_pkg.sv =====
// Shared types, widths and codes for the pulse template matcher.
// No dependencies; every other file refers to it by scoped names.
package ptm_pkg;

	localparam int PTM_MAX_DEFS = 16;
	localparam int RESULT_CAP   = 16;
	localparam int HIT_CNT_W    = 5;

	localparam int OP_W     = 2;
	localparam int BW_W     = 27;
	localparam int DUR_W    = 24;
	localparam int TOL_W    = 8;
	localparam int MODE_W   = 2;
	localparam int OUT_IDX_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
	localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

	localparam logic [MODE_W-1:0] MODE_BOTH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BW   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DUR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FREQ_TOL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_TOL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd2;

	localparam logic [TOL_W-1:0]  FREQ_TOL_RST = 8'd26;
	localparam logic [TOL_W-1:0]  TIME_TOL_RST = 8'd26;
	localparam logic [MODE_W-1:0] MODE_RST     = MODE_BOTH;

	typedef struct packed {
		logic [TOL_W-1:0]  freq_tol;
		logic [TOL_W-1:0]  time_tol;
		logic [MODE_W-1:0] mode;
	} ptm_win_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} ptm_state_t;

endpackage

// ===== rtl/pulse_template_matcher_unit.sv =====
// Pulse template matcher: load, clear and classify against a table of definitions.
// Load and clear: one result, registered as pending and sent from the flush state;
// the next item is taken only once the block is back in idle. Classify walks one
// definition per cycle through the shared window unit while the output is not
// stalled, and takes no new item until its last result has been sent.
// Async reset clears control, empties the table and restores tolerances and mode.
module pulse_template_matcher_unit #(
	parameter int MAX_DEFS = ptm_pkg::PTM_MAX_DEFS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ptm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ptm_pkg::OP_W-1:0]          op,
	input  logic [ptm_pkg::BW_W-1:0]          bandwidth_hz,
	input  logic [ptm_pkg::DUR_W-1:0]         dur_us,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ptm_pkg::OUT_IDX_W-1:0]     def_index,
	output logic                              matched,
	output logic                              last,
	output logic                              status
);

	localparam int IDX_W = (MAX_DEFS > 1) ? $clog2(MAX_DEFS) : 1;
	localparam int CNT_W = $clog2(MAX_DEFS + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_DEFS);
	localparam logic [ptm_pkg::HIT_CNT_W-1:0] HIT_CAP =
		ptm_pkg::HIT_CNT_W'(ptm_pkg::RESULT_CAP);

	ptm_pkg::ptm_state_t      state_q, state_nxt;
	ptm_pkg::ptm_win_cfg_t    cfg_q;

	logic [CNT_W-1:0]                 count_q, rd_q;
	logic [ptm_pkg::HIT_CNT_W-1:0]    n_q;
	logic                             s1_v_q, s2_v_q;
	logic [IDX_W-1:0]                 s1_idx_q, s2_idx_q;
	logic [ptm_pkg::BW_W-1:0]         feat_bw_q, rbw;
	logic [ptm_pkg::DUR_W-1:0]        feat_dur_q, rdur;

	logic                             pend_v_q, pend_match_q, pend_stat_q;
	logic [ptm_pkg::OUT_IDX_W-1:0]    pend_idx_q;
	logic                             out_valid_q;

	logic in_xfer, out_free, adv, scan_active, flush_go;
	logic issue_more, issue, scan_done, full, hit, take_hit, load_ok;

	assign in_xfer    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign adv        = out_free;
	assign full       = (count_q == FULL_CNT);
	assign load_ok    = in_xfer && (op == ptm_pkg::OP_LOAD) && !full;
	assign issue_more = (rd_q < count_q) && (n_q < HIT_CAP);
	assign issue      = scan_active && adv && issue_more;
	assign scan_done  = scan_active && !issue_more && !s1_v_q && !s2_v_q;
	assign take_hit   = scan_active && adv && s2_v_q && hit && (n_q < HIT_CAP);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ptm_pkg::ST_IDLE: begin
				if (in_xfer) begin
					priority if (op == ptm_pkg::OP_CLASSIFY) state_nxt = ptm_pkg::ST_SCAN;
					else if (op == ptm_pkg::OP_LOAD || op == ptm_pkg::OP_CLEAR)
						state_nxt = ptm_pkg::ST_FLUSH;
					else state_nxt = ptm_pkg::ST_IDLE;
				end
			end
			ptm_pkg::ST_SCAN: begin
				if (scan_done) state_nxt = ptm_pkg::ST_FLUSH;
			end
			ptm_pkg::ST_FLUSH: begin
				if (out_free) state_nxt = ptm_pkg::ST_IDLE;
			end
			default: state_nxt = ptm_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready    = 1'b0;
		scan_active = 1'b0;
		flush_go    = 1'b0;
		unique case (state_q)
			ptm_pkg::ST_IDLE:  in_ready = 1'b1;
			ptm_pkg::ST_SCAN:  scan_active = 1'b1;
			ptm_pkg::ST_FLUSH: flush_go = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freq_tol <= ptm_pkg::FREQ_TOL_RST;
			cfg_q.time_tol <= ptm_pkg::TIME_TOL_RST;
			cfg_q.mode     <= ptm_pkg::MODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptm_pkg::REG_FREQ_TOL: cfg_q.freq_tol <= cfg_data;
				ptm_pkg::REG_TIME_TOL: cfg_q.time_tol <= cfg_data;
				ptm_pkg::REG_MODE:     cfg_q.mode <= cfg_data[ptm_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_xfer && op == ptm_pkg::OP_CLEAR) begin
			count_q <= '0;
		end else if (load_ok) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && op == ptm_pkg::OP_CLASSIFY) begin
			feat_bw_q  <= bandwidth_hz;
			feat_dur_q <= dur_us;
		end
	end

	// scan pipeline: table read, span register, compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= '0;
			n_q    <= '0;
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				rd_q <= '0;
				n_q  <= '0;
			end else begin
				if (issue) rd_q <= rd_q + CNT_W'(1);
				if (take_hit) n_q <= n_q + ptm_pkg::HIT_CNT_W'(1);
			end
			if (adv) begin
				s1_v_q <= issue;
				s2_v_q <= s1_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_idx_q <= rd_q[IDX_W-1:0];
			s2_idx_q <= s1_idx_q;
		end
	end

	ptm_def_store #(
		.MAX_DEFS (MAX_DEFS),
		.IDX_W    (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (load_ok),
		.waddr (count_q[IDX_W-1:0]),
		.wbw   (bandwidth_hz),
		.wdur  (dur_us),
		.re    (issue),
		.raddr (rd_q[IDX_W-1:0]),
		.rbw   (rbw),
		.rdur  (rdur)
	);

	ptm_window_unit u_window (
		.clk      (clk),
		.adv      (adv),
		.def_bw   (rbw),
		.def_dur  (rdur),
		.feat_bw  (feat_bw_q),
		.feat_dur (feat_dur_q),
		.cfg      (cfg_q),
		.hit      (hit)
	);

	// hold the newest hit until the next one proves it is not last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else begin
			priority if (in_xfer && (op == ptm_pkg::OP_LOAD || op == ptm_pkg::OP_CLEAR))
				pend_v_q <= 1'b1;
			else if (take_hit || scan_done) pend_v_q <= 1'b1;
			else if (flush_go) pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		priority if (in_xfer && op == ptm_pkg::OP_LOAD) begin
			pend_idx_q   <= full ? '0 : ptm_pkg::OUT_IDX_W'(count_q[IDX_W-1:0]);
			pend_match_q <= 1'b0;
			pend_stat_q  <= full;
		end else if (in_xfer && op == ptm_pkg::OP_CLEAR) begin
			pend_idx_q   <= '0;
			pend_match_q <= 1'b0;
			pend_stat_q  <= 1'b0;
		end else if (take_hit) begin
			pend_idx_q   <= ptm_pkg::OUT_IDX_W'(s2_idx_q);
			pend_match_q <= 1'b1;
			pend_stat_q  <= 1'b0;
		end else if (scan_done && !pend_v_q) begin
			pend_idx_q   <= '0;
			pend_match_q <= 1'b0;
			pend_stat_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((take_hit && pend_v_q) || flush_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((take_hit && pend_v_q) || flush_go) begin
			def_index <= pend_idx_q;
			matched   <= pend_match_q;
			status    <= pend_stat_q;
			last      <= flush_go;
		end
	end

	assign out_valid = out_valid_q;

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!s1_v_q && !s2_v_q && !pend_v_q))
		else $error("input taken while scan pipeline or pending result busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("definition count above table depth");

	a_hit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= HIT_CAP)
		else $error("match count above result cap");

	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptm_pkg::ST_FLUSH) |-> pend_v_q)
		else $error("flush with no pending result");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(take_hit && pend_v_q) |-> out_free)
		else $error("result pushed into a full output register");

endmodule

// ===== rtl/ptm_def_store.sv =====
// Definition table: bandwidth and duration memories, one write and one read port.
// Read data is registered. Uses ptm_pkg for field widths.
module ptm_def_store #(
	parameter int MAX_DEFS = ptm_pkg::PTM_MAX_DEFS,
	parameter int IDX_W    = 4
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [IDX_W-1:0]             waddr,
	input  logic [ptm_pkg::BW_W-1:0]     wbw,
	input  logic [ptm_pkg::DUR_W-1:0]    wdur,
	input  logic                         re,
	input  logic [IDX_W-1:0]             raddr,
	output logic [ptm_pkg::BW_W-1:0]     rbw,
	output logic [ptm_pkg::DUR_W-1:0]    rdur
);

	logic [ptm_pkg::BW_W-1:0]  bw_mem  [MAX_DEFS];
	logic [ptm_pkg::DUR_W-1:0] dur_mem [MAX_DEFS];

	always_ff @(posedge clk) begin
		if (we) begin
			bw_mem[waddr]  <= wbw;
			dur_mem[waddr] <= wdur;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rbw  <= bw_mem[raddr];
			rdur <= dur_mem[raddr];
		end
	end

endmodule

// ===== rtl/ptm_window_unit.sv =====
// Shared window check: registers the tolerance spans of one definition, then
// tests the feature against both windows and applies the match mode. Uses ptm_pkg.
module ptm_window_unit (
	input  logic                         clk,
	input  logic                         adv,
	input  logic [ptm_pkg::BW_W-1:0]     def_bw,
	input  logic [ptm_pkg::DUR_W-1:0]    def_dur,
	input  logic [ptm_pkg::BW_W-1:0]     feat_bw,
	input  logic [ptm_pkg::DUR_W-1:0]    feat_dur,
	input  ptm_pkg::ptm_win_cfg_t        cfg,
	output logic                         hit
);

	localparam int PBW_W  = ptm_pkg::BW_W + ptm_pkg::TOL_W;
	localparam int PDUR_W = ptm_pkg::DUR_W + ptm_pkg::TOL_W;

	logic [PBW_W-1:0]            prod_bw;
	logic [PDUR_W-1:0]           prod_dur;
	logic [ptm_pkg::BW_W-1:0]    def_bw_s2, span_bw_s2, lo_bw;
	logic [ptm_pkg::DUR_W-1:0]   def_dur_s2, span_dur_s2, lo_dur;
	logic [ptm_pkg::BW_W:0]      hi_bw;
	logic [ptm_pkg::DUR_W:0]     hi_dur;
	logic                        bw_ok, dur_ok;

	assign prod_bw  = PBW_W'(def_bw) * PBW_W'(cfg.freq_tol);
	assign prod_dur = PDUR_W'(def_dur) * PDUR_W'(cfg.time_tol);

	always_ff @(posedge clk) begin
		if (adv) begin
			def_bw_s2   <= def_bw;
			def_dur_s2  <= def_dur;
			span_bw_s2  <= prod_bw[PBW_W-1:ptm_pkg::TOL_W];
			span_dur_s2 <= prod_dur[PDUR_W-1:ptm_pkg::TOL_W];
		end
	end

	// span never exceeds the definition, so the low edge cannot wrap
	assign lo_bw  = def_bw_s2 - span_bw_s2;
	assign hi_bw  = {1'b0, def_bw_s2} + {1'b0, span_bw_s2};
	assign lo_dur = def_dur_s2 - span_dur_s2;
	assign hi_dur = {1'b0, def_dur_s2} + {1'b0, span_dur_s2};

	assign bw_ok  = (feat_bw >= lo_bw) && ({1'b0, feat_bw} <= hi_bw);
	assign dur_ok = (feat_dur >= lo_dur) && ({1'b0, feat_dur} <= hi_dur);

	always_comb begin
		unique case (cfg.mode)
			ptm_pkg::MODE_BOTH: hit = bw_ok && dur_ok;
			ptm_pkg::MODE_BW:   hit = bw_ok;
			ptm_pkg::MODE_DUR:  hit = dur_ok;
			default:            hit = 1'b0;
		endcase
	end

endmodule

// ===== tb/ptm_checker.sv =====
`timescale 1ns / 1ps
// Report checker for the pulse template matcher: mirrors the definition table and
// window settings, predicts each report and compares it with what the block sends.
// Depends on ptm_pkg for widths, operation, mode and register codes.
module ptm_checker #(
	parameter int TABLE_DEPTH = ptm_pkg::PTM_MAX_DEFS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ptm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [ptm_pkg::OP_W-1:0]       op,
	input  logic [ptm_pkg::BW_W-1:0]       bandwidth_hz,
	input  logic [ptm_pkg::DUR_W-1:0]      dur_us,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [ptm_pkg::OUT_IDX_W-1:0]  def_index,
	input  logic                           matched,
	input  logic                           last,
	input  logic                           status,
	output int                             errors,
	output int                             outstanding,
	output int                             reports_checked,
	output int                             match_reports,
	output int                             refusals,
	output int                             widest_match
);

	localparam int SHOWN_MAX = 10;

	typedef struct packed {
		logic [ptm_pkg::OUT_IDX_W-1:0] def_index;
		logic                          matched;
		logic                          last;
		logic                          status;
	} report_t;

	report_t                    due_reports[$];
	logic [ptm_pkg::BW_W-1:0]   tbl_bw[TABLE_DEPTH];
	logic [ptm_pkg::DUR_W-1:0]  tbl_dur[TABLE_DEPTH];
	int unsigned                tbl_fill;
	logic [ptm_pkg::TOL_W-1:0]  bw_tol;
	logic [ptm_pkg::TOL_W-1:0]  dur_tol;
	logic [ptm_pkg::MODE_W-1:0] win_mode;

	function automatic bit in_band(longint unsigned value, longint unsigned anchor,
			longint unsigned tol);
		longint unsigned span;
		span = (anchor * tol) >> 8;
		return value >= anchor - span && value <= anchor + span;
	endfunction

	function automatic report_t make_report(int unsigned idx, bit hit, bit fin, bit stat);
		report_t r;
		r.def_index = ptm_pkg::OUT_IDX_W'(idx);
		r.matched   = hit;
		r.last      = fin;
		r.status    = stat;
		return r;
	endfunction

	task automatic predict_table_op(input logic [ptm_pkg::OP_W-1:0] code,
			input logic [ptm_pkg::BW_W-1:0] bw, input logic [ptm_pkg::DUR_W-1:0] dur);
		int  hits;
		bit  bw_ok;
		bit  dur_ok;
		bit  hit;
		hits = 0;
		case (code)
			ptm_pkg::OP_LOAD: begin
				if (tbl_fill >= TABLE_DEPTH) begin
					due_reports = {due_reports, make_report(0, 1'b0, 1'b1, 1'b1)};
				end else begin
					tbl_bw[tbl_fill]  = bw;
					tbl_dur[tbl_fill] = dur;
					due_reports = {due_reports, make_report(tbl_fill, 1'b0, 1'b1, 1'b0)};
					tbl_fill++;
				end
			end
			ptm_pkg::OP_CLEAR: begin
				tbl_fill = 0;
				due_reports = {due_reports, make_report(0, 1'b0, 1'b1, 1'b0)};
			end
			ptm_pkg::OP_CLASSIFY: begin
				for (int i = 0; i < tbl_fill; i++) begin
					bw_ok  = in_band(bw, tbl_bw[i], bw_tol);
					dur_ok = in_band(dur, tbl_dur[i], dur_tol);
					case (win_mode)
						ptm_pkg::MODE_BOTH: hit = bw_ok && dur_ok;
						ptm_pkg::MODE_BW:   hit = bw_ok;
						ptm_pkg::MODE_DUR:  hit = dur_ok;
						default:            hit = 1'b0;
					endcase
					if (hit && hits < ptm_pkg::RESULT_CAP) begin
						due_reports = {due_reports, make_report(i, 1'b1, 1'b0, 1'b0)};
						hits++;
					end
				end
				if (hits == 0)
					due_reports = {due_reports, make_report(0, 1'b0, 1'b1, 1'b0)};
				else
					due_reports[due_reports.size() - 1].last = 1'b1;
				if (hits > widest_match)
					widest_match = hits;
			end
			default: ; // drop: unused operation code
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t got;
		report_t want;
		if (!arst_n) begin
			due_reports.delete();
			tbl_fill        = 0;
			bw_tol          = ptm_pkg::FREQ_TOL_RST;
			dur_tol         = ptm_pkg::TIME_TOL_RST;
			win_mode        = ptm_pkg::MODE_RST;
			errors          = 0;
			reports_checked = 0;
			match_reports   = 0;
			refusals        = 0;
			widest_match    = 0;
			outstanding    <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ptm_pkg::REG_FREQ_TOL: bw_tol   = cfg_data[ptm_pkg::TOL_W-1:0];
					ptm_pkg::REG_TIME_TOL: dur_tol  = cfg_data[ptm_pkg::TOL_W-1:0];
					ptm_pkg::REG_MODE:     win_mode = cfg_data[ptm_pkg::MODE_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = {def_index, matched, last, status};
				if (due_reports.size() == 0) begin
					errors++;
					if (errors <= SHOWN_MAX)
						$display("%0t: unexpected report idx=%0d matched=%0b last=%0b status=%0b",
							$time, got.def_index, got.matched, got.last, got.status);
				end else begin
					want = due_reports.pop_front();
					reports_checked++;
					if (want.matched)
						match_reports++;
					if (want.status)
						refusals++;
					if (got.def_index !== want.def_index || got.matched !== want.matched ||
							got.last !== want.last || got.status !== want.status) begin
						errors++;
						if (errors <= SHOWN_MAX)
							$display("%0t: report mismatch: expected idx=%0d matched=%0b",
								$time, want.def_index, want.matched,
								" last=%0b status=%0b, got idx=%0d matched=%0b",
								want.last, want.status, got.def_index, got.matched,
								" last=%0b status=%0b", got.last, got.status);
					end
				end
			end
			if (in_valid && in_ready)
				predict_table_op(op, bandwidth_hz, dur_us);
			outstanding <= due_reports.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the pulse template matcher testbench: clock, reset, stimulus and verdict.
// Depends on ptm_pkg, pulse_template_matcher_unit and ptm_checker.
module testbench;

	localparam int     ITEM_TARGET     = 460;
	localparam int     IDLE_PCT        = 14;
	localparam int     HOLD_OFF_CYCLES = 120;
	localparam int     SETTLE_CYCLES   = 30;
	localparam longint TIMEOUT_NS      = 5_000_000;
	localparam logic [ptm_pkg::CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
	localparam logic [ptm_pkg::MODE_W-1:0]    MODE_UNUSED = 2'd3;
	localparam logic [ptm_pkg::OP_W-1:0]      OP_UNUSED   = 2'd3;
	localparam longint BW_MASK  = (longint'(1) << ptm_pkg::BW_W) - 1;
	localparam longint DUR_MASK = (longint'(1) << ptm_pkg::DUR_W) - 1;
	localparam logic [ptm_pkg::BW_W-1:0]  BW_TOP  = '1;
	localparam logic [ptm_pkg::DUR_W-1:0] DUR_TOP = '1;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           cfg_we       = 1'b0;
	logic [ptm_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [ptm_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
	logic                           in_valid     = 1'b0;
	logic                           in_ready;
	logic [ptm_pkg::OP_W-1:0]       op           = ptm_pkg::OP_LOAD;
	logic [ptm_pkg::BW_W-1:0]       bandwidth_hz = '0;
	logic [ptm_pkg::DUR_W-1:0]      dur_us       = '0;
	logic                           out_valid;
	logic                           out_ready    = 1'b0;
	logic [ptm_pkg::OUT_IDX_W-1:0]  def_index;
	logic                           matched;
	logic                           last;
	logic                           status;

	int errors;
	int outstanding;
	int reports_checked;
	int match_reports;
	int refusals;
	int widest_match;

	bit                        quiet        = 1'b0;
	bit                        hold_off_req = 1'b0;
	int                        items_sent   = 0;
	int                        phases       = 0;
	int                        hold_offs    = 0;
	logic [ptm_pkg::TOL_W-1:0] bw_tol_now   = ptm_pkg::FREQ_TOL_RST;
	logic [ptm_pkg::TOL_W-1:0] dur_tol_now  = ptm_pkg::TIME_TOL_RST;
	longint                    loaded_bw[$];
	longint                    loaded_dur[$];

	always #5 clk = ~clk;

	pulse_template_matcher_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.bandwidth_hz (bandwidth_hz),
		.dur_us       (dur_us),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.def_index    (def_index),
		.matched      (matched),
		.last         (last),
		.status       (status)
	);

	ptm_checker u_match_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.bandwidth_hz    (bandwidth_hz),
		.dur_us          (dur_us),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.def_index       (def_index),
		.matched         (matched),
		.last            (last),
		.status          (status),
		.errors          (errors),
		.outstanding     (outstanding),
		.reports_checked (reports_checked),
		.match_reports   (match_reports),
		.refusals        (refusals),
		.widest_match    (widest_match)
	);

	// Offer one item and hold it until the transfer; valid stays high for a follow-on item.
	task automatic send_item(input logic [ptm_pkg::OP_W-1:0] code,
			input logic [ptm_pkg::BW_W-1:0] bw, input logic [ptm_pkg::DUR_W-1:0] dur);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		op           <= code;
		bandwidth_hz <= bw;
		dur_us       <= dur;
		do @(posedge clk); while (!in_ready);
		if (code != OP_UNUSED)
			items_sent++;
		if (code == ptm_pkg::OP_LOAD && loaded_bw.size() < ptm_pkg::PTM_MAX_DEFS) begin
			loaded_bw  = {loaded_bw, longint'(bw)};
			loaded_dur = {loaded_dur, longint'(dur)};
		end else if (code == ptm_pkg::OP_CLEAR) begin
			loaded_bw.delete();
			loaded_dur.delete();
		end
	endtask

	// Drain all reports, then give an ignored item time to leave the block.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_windows(input logic [ptm_pkg::TOL_W-1:0] ft,
			input logic [ptm_pkg::TOL_W-1:0] tt, input logic [ptm_pkg::MODE_W-1:0] md,
			input bit stray);
		cfg_we    <= 1'b1;
		cfg_index <= ptm_pkg::REG_FREQ_TOL;
		cfg_data  <= ft;
		@(posedge clk);
		cfg_index <= ptm_pkg::REG_TIME_TOL;
		cfg_data  <= tt;
		@(posedge clk);
		// upper data bits are junk the block must drop
		cfg_index <= ptm_pkg::REG_MODE;
		cfg_data  <= {(ptm_pkg::CFG_DATA_W - ptm_pkg::MODE_W)'($urandom), md};
		@(posedge clk);
		if (stray) begin
			cfg_index <= REG_UNUSED;
			cfg_data  <= ptm_pkg::CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		cfg_we      <= 1'b0;
		bw_tol_now  = ft;
		dur_tol_now = tt;
	endtask

	// Value on, just past, or around the window edge of a stored definition.
	function automatic longint near_value(longint anchor, longint tol, longint mask);
		longint span;
		longint off;
		longint reach;
		span = (anchor * tol) >> 8;
		case ($urandom_range(0, 3))
			0:       off = span + longint'($urandom_range(0, 1));
			1:       off = -(span + longint'($urandom_range(0, 1)));
			default: begin
				reach = span + span / 4 + 2;
				off   = longint'($urandom_range(0, 32'(2 * reach))) - reach;
			end
		endcase
		return (anchor + off) & mask;
	endfunction

	function automatic longint pick_anchor(longint mask);
		case ($urandom_range(0, 3))
			0:       return longint'($urandom_range(0, 300));
			1:       return mask - longint'($urandom_range(0, 3000));
			2:       return longint'($urandom) & mask;
			default: return longint'($urandom_range(1000, 5_000_000)) & mask;
		endcase
	endfunction

	// Receiver: random stalls, plus a long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				hold_offs++;
			end
			out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d reports still pending", outstanding);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		longint                     base_bw;
		longint                     base_dur;
		longint                     spread_bw;
		longint                     spread_dur;
		int                         j;
		logic [ptm_pkg::TOL_W-1:0]  ft;
		logic [ptm_pkg::TOL_W-1:0]  tt;
		logic [ptm_pkg::MODE_W-1:0] md;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset window settings.
		send_item(ptm_pkg::OP_CLASSIFY, 27'd5, 24'd5);              // empty table
		send_item(ptm_pkg::OP_CLEAR, BW_TOP, DUR_TOP);
		send_item(ptm_pkg::OP_LOAD, '0, '0);
		send_item(ptm_pkg::OP_LOAD, BW_TOP, DUR_TOP);
		send_item(ptm_pkg::OP_LOAD, 27'd1_000_000, 24'd50_000);
		send_item(ptm_pkg::OP_CLASSIFY, '0, '0);                    // zero-width window
		send_item(ptm_pkg::OP_CLASSIFY, BW_TOP, DUR_TOP);
		send_item(ptm_pkg::OP_CLASSIFY, 27'd898_438, 24'd44_922);   // lower window edges
		send_item(ptm_pkg::OP_CLASSIFY, 27'd1_101_563, 24'd50_000); // one past upper edge
		send_item(OP_UNUSED, BW_TOP, DUR_TOP);
		repeat (13) send_item(ptm_pkg::OP_LOAD, 27'd1_000_000, 24'd50_000);
		send_item(ptm_pkg::OP_LOAD, 27'd7, 24'd7);                  // table full
		send_item(ptm_pkg::OP_CLASSIFY, 27'd1_000_000, 24'd50_000);
		send_item(ptm_pkg::OP_CLEAR, '0, '0);

		while (items_sent < ITEM_TARGET) begin
			phases++;
			settle();
			quiet = (phases >= 6 && phases <= 8);
			case (phases)
				1: begin ft = '0; tt = '0; md = ptm_pkg::MODE_BOTH; end
				2: begin ft = '1; tt = '1; md = ptm_pkg::MODE_BOTH; end
				3: begin ft = '1; tt = '0; md = ptm_pkg::MODE_BW; end
				4: begin ft = '0; tt = '1; md = ptm_pkg::MODE_DUR; end
				5: begin
					ft = ptm_pkg::FREQ_TOL_RST;
					tt = ptm_pkg::TIME_TOL_RST;
					md = MODE_UNUSED;
				end
				default: begin
					case ($urandom_range(0, 3))
						0:       ft = '0;
						1:       ft = '1;
						default: ft = ptm_pkg::TOL_W'($urandom_range(1, 254));
					endcase
					case ($urandom_range(0, 3))
						0:       tt = '0;
						1:       tt = '1;
						default: tt = ptm_pkg::TOL_W'($urandom_range(1, 254));
					endcase
					case ($urandom_range(0, 9))
						0:             md = MODE_UNUSED;
						1, 2:          md = ptm_pkg::MODE_BW;
						3, 4:          md = ptm_pkg::MODE_DUR;
						default:       md = ptm_pkg::MODE_BOTH;
					endcase
				end
			endcase
			write_windows(ft, tt, md, $urandom_range(0, 2) == 0);
			if (phases == 3 || phases == 11)
				hold_off_req = 1'b1;

			// Mostly: clear, load a cluster of definitions, then classify near them.
			if ($urandom_range(0, 3) != 0)
				send_item(ptm_pkg::OP_CLEAR, ptm_pkg::BW_W'($urandom),
					ptm_pkg::DUR_W'($urandom));
			base_bw    = pick_anchor(BW_MASK);
			base_dur   = pick_anchor(DUR_MASK);
			spread_bw  = ($urandom_range(0, 2) == 0) ? 0 : (base_bw >> $urandom_range(2, 8)) + 1;
			spread_dur = ($urandom_range(0, 2) == 0) ? 0 :
				(base_dur >> $urandom_range(2, 8)) + 1;
			repeat ($urandom_range(0, 19)) begin
				if ($urandom_range(0, 4) == 0)
					send_item(ptm_pkg::OP_LOAD, ptm_pkg::BW_W'($urandom),
						ptm_pkg::DUR_W'($urandom));
				else
					send_item(ptm_pkg::OP_LOAD,
						ptm_pkg::BW_W'((base_bw + longint'($urandom_range(0, 32'(spread_bw))))
							& BW_MASK),
						ptm_pkg::DUR_W'((base_dur
							+ longint'($urandom_range(0, 32'(spread_dur)))) & DUR_MASK));
			end
			repeat ($urandom_range(6, 20)) begin
				case ($urandom_range(0, 19))
					0:       send_item(OP_UNUSED, ptm_pkg::BW_W'($urandom),
						ptm_pkg::DUR_W'($urandom));
					1:       send_item(ptm_pkg::OP_CLEAR, ptm_pkg::BW_W'($urandom),
						ptm_pkg::DUR_W'($urandom));
					2:       send_item(ptm_pkg::OP_LOAD, ptm_pkg::BW_W'($urandom),
						ptm_pkg::DUR_W'($urandom));
					3, 4:    send_item(ptm_pkg::OP_CLASSIFY, ptm_pkg::BW_W'($urandom),
						ptm_pkg::DUR_W'($urandom));
					default: begin
						if (loaded_bw.size() == 0) begin
							send_item(ptm_pkg::OP_CLASSIFY,
								ptm_pkg::BW_W'(near_value(base_bw, bw_tol_now, BW_MASK)),
								ptm_pkg::DUR_W'(near_value(base_dur, dur_tol_now, DUR_MASK)));
						end else begin
							j = $urandom_range(0, loaded_bw.size() - 1);
							send_item(ptm_pkg::OP_CLASSIFY,
								ptm_pkg::BW_W'(near_value(loaded_bw[j], bw_tol_now, BW_MASK)),
								ptm_pkg::DUR_W'(near_value(loaded_dur[j], dur_tol_now,
									DUR_MASK)));
						end
					end
				endcase
			end
		end

		settle();
		$display("Sent %0d items across %0d window settings; checked %0d reports,",
			items_sent, phases + 1, reports_checked,
			" %0d of them matches, %0d full-table refusals.", match_reports, refusals);
		$display("Largest match set was %0d definitions;", widest_match,
			" receiver held off for long stretches %0d times.", hold_offs);
		if (errors == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== pulse_template_matcher_unit.f =====
rtl/ptm_pkg.sv
rtl/ptm_def_store.sv
rtl/ptm_window_unit.sv
rtl/pulse_template_matcher_unit.sv
tb/ptm_checker.sv
tb/testbench.sv
